/* rtl/kwsc_pkg.sv */
`timescale 1ns / 1ps

package kwsc_pkg;

   // Number of letters in the full alphabet and the width of a letter index.
   localparam int LETTER_SLOTS = 26;
   localparam int IDX_W        = 5;
   localparam int CHAR_W       = 8;

   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;

   typedef enum logic [1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_KEY    = 2'd1,
      MODE_FINISH = 2'd2,
      MODE_DATA   = 2'd3
   } mode_type;

   typedef struct packed {
      logic             valid;
      logic             upper;
      logic [IDX_W-1:0] idx;
   } letter_type;

   // Request from the sequencer to the alphabet store.
   typedef struct packed {
      logic             clear;
      logic             place;
      logic [IDX_W-1:0] idx;
   } tbl_op_type;

   // Letters at or beyond the alphabet size count as non-letters.
   function automatic letter_type letter_decode(input logic [CHAR_W-1:0] ch,
                                                input int size);
      letter_type res;
      logic [CHAR_W-1:0] off;
      res = '0;
      off = '0;
      if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
         off       = ch - CH_UPPER_A;
         res.valid = 1'b1;
         res.upper = 1'b1;
      end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
         off       = ch - CH_LOWER_A;
         res.valid = 1'b1;
      end
      res.idx = off[IDX_W-1:0];
      if (res.valid && (int'(off) >= size)) begin
         res.valid = 1'b0;
      end
      return res;
   endfunction

endpackage

/* rtl/kwsc_table.sv */
`timescale 1ns / 1ps

module kwsc_table #(
   parameter int ALPHABET_SIZE = kwsc_pkg::LETTER_SLOTS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  kwsc_pkg::tbl_op_type       op,
   output logic [kwsc_pkg::IDX_W-1:0] sub
);
   import kwsc_pkg::*;

   localparam int AW = $clog2(ALPHABET_SIZE);
   localparam int FW = $clog2(ALPHABET_SIZE + 1);

   logic [ALPHABET_SIZE-1:0] seen_ff;
   logic [IDX_W-1:0]         alphabet_ff [ALPHABET_SIZE];
   logic [FW-1:0]            fill_ff;
   logic                     do_place;
   logic                     has_room;

   // The place unit appends a letter only the first time it is seen.
   assign do_place = op.place && !seen_ff[op.idx[AW-1:0]];
   assign has_room = fill_ff < FW'(ALPHABET_SIZE);
   assign sub      = alphabet_ff[op.idx[AW-1:0]];

   always_ff @(posedge clock) begin
      if (reset || op.clear) begin
         seen_ff <= '0;
         fill_ff <= '0;
         for (int i = 0; i < ALPHABET_SIZE; i++) begin
            alphabet_ff[i] <= IDX_W'(i);
         end
      end else if (do_place) begin
         seen_ff[op.idx[AW-1:0]] <= 1'b1;
         if (has_room) begin
            alphabet_ff[fill_ff[AW-1:0]] <= op.idx;
            fill_ff                      <= fill_ff + 1'b1;
         end
      end
   end

endmodule

/* rtl/kwsc_ctrl.sv */
`timescale 1ns / 1ps

module kwsc_ctrl #(
   parameter int ALPHABET_SIZE = kwsc_pkg::LETTER_SLOTS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [kwsc_pkg::CHAR_W-1:0] req_tdata,
   input  logic [1:0]                  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [kwsc_pkg::CHAR_W-1:0] rsp_tdata,
   output kwsc_pkg::tbl_op_type        op,
   input  logic [kwsc_pkg::IDX_W-1:0]  sub
);
   import kwsc_pkg::*;

   localparam int AW = $clog2(ALPHABET_SIZE);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_WALK = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     walk_ff, walk_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_data_ff, rsp_data_in;
   logic              accept;
   letter_type        dec;
   mode_type          mode;

   assign mode       = mode_type'(req_tuser);
   assign dec        = letter_decode(req_tdata, ALPHABET_SIZE);
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      walk_in      = walk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      op           = '0;
      op.idx       = dec.idx;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (mode)
                  MODE_CLEAR:  op.clear = 1'b1;
                  MODE_KEY:    op.place = dec.valid;
                  MODE_FINISH: begin
                     walk_in  = '0;
                     state_in = S_WALK;
                  end
                  MODE_DATA: begin
                     if (dec.valid) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = (dec.upper ? CH_UPPER_A : CH_LOWER_A)
                                       + CHAR_W'(sub);
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_WALK: begin
            // One letter a cycle goes through the shared place unit.
            op.place = 1'b1;
            op.idx   = IDX_W'(walk_ff);
            walk_in  = walk_ff + 1'b1;
            if (walk_ff == AW'(ALPHABET_SIZE - 1)) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* rtl/keyword_substitution_cipher.sv */
`timescale 1ns / 1ps

// Keyword substitution cipher over ASCII bytes.
// Input channel req_*: tuser carries the mode (clear, key byte, finish, data
// byte) and tdata the byte. Output channel rsp_*: one enciphered letter per
// data byte that is a letter; every other word gives no result.
// A data word's result sits in the output register from the next cycle
// until taken. A finish word runs the letter walker, which sends one
// letter a cycle through the shared place unit, so the block is busy
// until the walker has passed all ALPHABET_SIZE letters (26 by default).
// req_tready is low while the walker runs, and also while a result is held
// and rsp_tready is low, so a stalled receiver stops the input side.
// Reset and a clear word empty the key and restore the cipher alphabet to
// the identity mapping. Reset also drops any pending result; a clear word
// is only taken once a held result has left.
module keyword_substitution_cipher #(
   parameter int ALPHABET_SIZE = kwsc_pkg::LETTER_SLOTS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [kwsc_pkg::CHAR_W-1:0] req_tdata,  // [7:0] char_in
   input  logic [1:0]                  req_tuser,  // [1:0] mode
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [kwsc_pkg::CHAR_W-1:0] rsp_tdata   // [7:0] char_out
);
   import kwsc_pkg::*;

   tbl_op_type       op;
   logic [IDX_W-1:0] sub;

   kwsc_ctrl #(
      .ALPHABET_SIZE(ALPHABET_SIZE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .op        (op),
      .sub       (sub)
   );

   kwsc_table #(
      .ALPHABET_SIZE(ALPHABET_SIZE)
   ) u_table (
      .clock(clock),
      .reset(reset),
      .op   (op),
      .sub  (sub)
   );

endmodule

/* rtl/kwsc_checker.sv */
`timescale 1ns / 1ps

module kwsc_props (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic [1:0] req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);
   import kwsc_pkg::*;

   logic acc;
   logic is_letter;

   assign acc       = req_tvalid && req_tready;
   assign is_letter = (req_tdata >= CH_UPPER_A && req_tdata <= CH_UPPER_Z) ||
                      (req_tdata >= CH_LOWER_A && req_tdata <= CH_LOWER_Z);

   // A held result keeps its word until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_rsp_letter: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >= CH_UPPER_A && rsp_tdata <= CH_UPPER_Z) ||
                     (rsp_tdata >= CH_LOWER_A && rsp_tdata <= CH_LOWER_Z))
      else $error("result is not a letter");

   a_no_rsp_nonletter: assert property (@(posedge clock) disable iff (reset)
      acc && !rsp_tvalid && !is_letter |=> !rsp_tvalid)
      else $error("result from a non-letter word");

   a_no_rsp_key: assert property (@(posedge clock) disable iff (reset)
      acc && !rsp_tvalid && req_tuser != MODE_DATA |=> !rsp_tvalid)
      else $error("result from a word that is not data");

   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      acc && req_tuser == MODE_FINISH |=> !req_tready)
      else $error("ready while the alphabet walk runs");

endmodule

bind keyword_substitution_cipher kwsc_props u_kwsc_props (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tdata (req_tdata),
   .req_tuser (req_tuser),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
